[hw/rtl/ilac_pkg.sv]
// ----------------------------------------------------------------------------
// ilac_pkg
// Shared types, widths and constants of the IMU lever-arm correction unit.
// ----------------------------------------------------------------------------
package ilac_pkg;

    // field and register widths
    localparam int REG_W    = 54;
    localparam int ENTRY_W  = 18;
    localparam int SAMPLE_W = 24;

    // rotated sums at Q.32 and rounded body rate
    localparam int PROD_W  = ENTRY_W + SAMPLE_W;   // 42
    localparam int AF_W    = 43;                   // three-term sum, bounded
    localparam int WR_W    = AF_W - 16;            // 27, rounded body rate

    // w x arm at Q.32 and its rounded form
    localparam int VF_W    = WR_W + ENTRY_W;       // 45
    localparam int VR_W    = VF_W - 16;            // 29

    // w x v at Q.32
    localparam int CF_W    = WR_W + VR_W;          // 56

    // acceleration minus centripetal term, then rounded
    localparam int DF_W    = CF_W + 1;             // 57
    localparam int RN_W    = DF_W - 16;            // 41

    // register index codes
    localparam logic [1:0] REG_ROT_X = 2'd0;
    localparam logic [1:0] REG_ROT_Y = 2'd1;
    localparam logic [1:0] REG_ROT_Z = 2'd2;
    localparam logic [1:0] REG_ARM   = 2'd3;

    // register reset values: identity rows, zero arm
    localparam logic [REG_W-1:0] ROT_X_RST = 54'h00_0000_0001_0000;
    localparam logic [REG_W-1:0] ROT_Y_RST = 54'h00_0004_0000_0000;
    localparam logic [REG_W-1:0] ROT_Z_RST = 54'h10_0000_0000_0000;
    localparam logic [REG_W-1:0] ARM_RST   = 54'h00_0000_0000_0000;

    // output clamp limits
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 24'sh800000;

    typedef logic signed [ENTRY_W-1:0]  t_entry;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [AF_W-1:0]     t_afull;
    typedef logic signed [WR_W-1:0]     t_wrate;
    typedef logic signed [VF_W-1:0]     t_vfull;
    typedef logic signed [VR_W-1:0]     t_vrnd;
    typedef logic signed [CF_W-1:0]     t_cfull;
    typedef logic signed [DF_W-1:0]     t_diff;
    typedef logic signed [RN_W-1:0]     t_rnd;

    typedef t_sample t_sample_vec [3];
    typedef t_afull  t_afull_vec  [3];
    typedef t_wrate  t_wrate_vec  [3];
    typedef t_cfull  t_cfull_vec  [3];

    // one signed Q1.16 entry out of a packed row
    function automatic t_entry get_entry(input logic [REG_W-1:0] row, input int k);
        return t_entry'(row[ENTRY_W*k +: ENTRY_W]);
    endfunction

endpackage

[hw/rtl/ilac_rot_lane.sv]
// ----------------------------------------------------------------------------
// ilac_rot_lane
// One rotation row: body acceleration sum and rounded body rate for one axis.
// ----------------------------------------------------------------------------
module ilac_rot_lane (
    input  logic                        i_clk,
    input  logic [ilac_pkg::REG_W-1:0]  i_row,
    input  ilac_pkg::t_sample_vec       i_acc,
    input  ilac_pkg::t_sample_vec       i_rate,
    output ilac_pkg::t_afull            o_a,
    output ilac_pkg::t_wrate            o_w
);
    import ilac_pkg::*;

    t_prod  r_pa [3];
    t_prod  r_pw [3];
    t_afull n_a;
    t_afull n_wsum;

    // row entry times sample component
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_pa[j] <= get_entry(i_row, j) * i_acc[j];
            r_pw[j] <= get_entry(i_row, j) * i_rate[j];
        end
    end

    // three-term sums, rate rounded half up
    always_comb begin
        n_a    = t_afull'(r_pa[0]) + t_afull'(r_pa[1]) + t_afull'(r_pa[2]);
        n_wsum = t_afull'(r_pw[0]) + t_afull'(r_pw[1]) + t_afull'(r_pw[2])
               + t_afull'(1 << 15);
    end

    always_ff @(posedge i_clk) begin
        o_a <= n_a;
        o_w <= t_wrate'(n_wsum[AF_W-1:16]);
    end

endmodule

[hw/rtl/ilac_arm_lane.sv]
// ----------------------------------------------------------------------------
// ilac_arm_lane
// One component of w x arm, rounded to Q.16.
// ----------------------------------------------------------------------------
module ilac_arm_lane (
    input  logic              i_clk,
    input  ilac_pkg::t_wrate  i_w1,
    input  ilac_pkg::t_wrate  i_w2,
    input  ilac_pkg::t_entry  i_b1,
    input  ilac_pkg::t_entry  i_b2,
    output ilac_pkg::t_vrnd   o_v
);
    import ilac_pkg::*;

    t_vfull r_p1;
    t_vfull r_p2;
    t_vfull n_vf;

    // cross product terms
    always_ff @(posedge i_clk) begin
        r_p1 <= i_w1 * i_b2;
        r_p2 <= i_w2 * i_b1;
    end

    // difference with rounding offset
    always_comb begin
        n_vf = r_p1 - r_p2 + t_vfull'(1 << 15);
    end

    always_ff @(posedge i_clk) begin
        o_v <= t_vrnd'(n_vf[VF_W-1:16]);
    end

endmodule

[hw/rtl/ilac_cent_lane.sv]
// ----------------------------------------------------------------------------
// ilac_cent_lane
// One component of the centripetal term w x v at Q.32.
// ----------------------------------------------------------------------------
module ilac_cent_lane (
    input  logic              i_clk,
    input  ilac_pkg::t_wrate  i_w1,
    input  ilac_pkg::t_wrate  i_w2,
    input  ilac_pkg::t_vrnd   i_v1,
    input  ilac_pkg::t_vrnd   i_v2,
    output ilac_pkg::t_cfull  o_c
);
    import ilac_pkg::*;

    t_cfull r_p1;
    t_cfull r_p2;

    // cross product terms
    always_ff @(posedge i_clk) begin
        r_p1 <= i_w1 * i_v2;
        r_p2 <= i_w2 * i_v1;
    end

    // difference, bounded to the full width
    always_ff @(posedge i_clk) begin
        o_c <= r_p1 - r_p2;
    end

endmodule

[hw/rtl/ilac_merge.sv]
// ----------------------------------------------------------------------------
// ilac_merge
// Combines the lanes: subtracts the centripetal term, rounds, saturates and
// registers the result with its strobe and the clip flag.
// ----------------------------------------------------------------------------
module ilac_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ilac_pkg::t_afull_vec  i_a,
    input  ilac_pkg::t_cfull_vec  i_c,
    input  ilac_pkg::t_wrate_vec  i_w,
    output ilac_pkg::t_sample_vec o_acc,
    output ilac_pkg::t_sample_vec o_rate,
    output logic                  o_clipped,
    output logic                  o_valid
);
    import ilac_pkg::*;

    t_rnd    n_r   [3];
    t_sample n_acc [3];
    t_sample n_rate[3];
    logic    n_clip;

    // corrected acceleration and rate, clamped to 24 bits
    always_comb begin
        n_clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            t_diff d;
            d      = t_diff'(i_a[i]) - t_diff'(i_c[i]) + t_diff'(1 << 15);
            n_r[i] = t_rnd'(d[DF_W-1:16]);
            if (n_r[i] > OUT_MAX) begin
                n_acc[i] = OUT_MAX;
                n_clip   = 1'b1;
            end else if (n_r[i] < OUT_MIN) begin
                n_acc[i] = OUT_MIN;
                n_clip   = 1'b1;
            end else begin
                n_acc[i] = n_r[i][SAMPLE_W-1:0];
            end
            if (i_w[i] > OUT_MAX) begin
                n_rate[i] = OUT_MAX;
                n_clip    = 1'b1;
            end else if (i_w[i] < OUT_MIN) begin
                n_rate[i] = OUT_MIN;
                n_clip    = 1'b1;
            end else begin
                n_rate[i] = i_w[i][SAMPLE_W-1:0];
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        o_acc     <= n_acc;
        o_rate    <= n_rate;
        o_clipped <= n_clip;
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

endmodule

[hw/rtl/imu_lever_arm_correction_unit.sv]
// ----------------------------------------------------------------------------
// imu_lever_arm_correction_unit
// A start goes through the rot, arm, cent and merge lanes to the o_valid strobe.
// Throughput: one sample per cycle; the multiply pipeline takes a new sample
// every cycle, so busy is never raised.
// Reset: clears the pipeline strobes; rotation rows return to identity and
// the lever arm to zero.
// ----------------------------------------------------------------------------
module imu_lever_arm_correction_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ilac_pkg::SAMPLE_W-1:0]  i_acc_x,
    input  logic [ilac_pkg::SAMPLE_W-1:0]  i_acc_y,
    input  logic [ilac_pkg::SAMPLE_W-1:0]  i_acc_z,
    input  logic [ilac_pkg::SAMPLE_W-1:0]  i_rate_x,
    input  logic [ilac_pkg::SAMPLE_W-1:0]  i_rate_y,
    input  logic [ilac_pkg::SAMPLE_W-1:0]  i_rate_z,
    output logic [ilac_pkg::SAMPLE_W-1:0]  o_body_acc_x,
    output logic [ilac_pkg::SAMPLE_W-1:0]  o_body_acc_y,
    output logic [ilac_pkg::SAMPLE_W-1:0]  o_body_acc_z,
    output logic [ilac_pkg::SAMPLE_W-1:0]  o_body_rate_x,
    output logic [ilac_pkg::SAMPLE_W-1:0]  o_body_rate_y,
    output logic [ilac_pkg::SAMPLE_W-1:0]  o_body_rate_z,
    output logic                           o_clipped,
    output logic                           o_valid,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [4:0]                     paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready
);
    import ilac_pkg::*;

    logic [REG_W-1:0] r_rot [3];
    logic [REG_W-1:0] r_arm;
    logic [1:0]       cfg_idx;
    logic             cfg_wr;
    logic [REG_W-1:0] rd_val;

    logic [5:0]       r_vld;

    t_sample_vec      acc_in;
    t_sample_vec      rate_in;
    t_afull_vec       lane_a;
    t_wrate_vec       lane_w;
    t_vrnd            lane_v [3];
    t_cfull_vec       lane_c;
    t_entry           arm_e  [3];

    t_afull           r_a_d  [4][3];
    t_wrate           r_w_d  [4][3];
    t_afull_vec       a_al;
    t_wrate_vec       w_al;
    t_wrate_vec       w_mid;

    t_sample_vec      out_acc;
    t_sample_vec      out_rate;

    assign busy    = 1'b0;
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    // register read decode
    always_comb begin
        unique case (cfg_idx)
            REG_ROT_X: rd_val = r_rot[0];
            REG_ROT_Y: rd_val = r_rot[1];
            REG_ROT_Z: rd_val = r_rot[2];
            REG_ARM:   rd_val = r_arm;
        endcase
    end
    assign prdata = 64'(rd_val);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= ROT_X_RST;
            r_rot[1] <= ROT_Y_RST;
            r_rot[2] <= ROT_Z_RST;
            r_arm    <= ARM_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ROT_X: r_rot[0] <= pwdata[REG_W-1:0];
                REG_ROT_Y: r_rot[1] <= pwdata[REG_W-1:0];
                REG_ROT_Z: r_rot[2] <= pwdata[REG_W-1:0];
                REG_ARM:   r_arm    <= pwdata[REG_W-1:0];
            endcase
        end
    end

    // pipeline strobes, one per register stage ahead of the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], start & ~busy};
        end
    end

    // sample vectors
    assign acc_in[0]  = t_sample'(i_acc_x);
    assign acc_in[1]  = t_sample'(i_acc_y);
    assign acc_in[2]  = t_sample'(i_acc_z);
    assign rate_in[0] = t_sample'(i_rate_x);
    assign rate_in[1] = t_sample'(i_rate_y);
    assign rate_in[2] = t_sample'(i_rate_z);

    // alignment delays for the lane sums and the body rate
    always_ff @(posedge i_clk) begin
        r_a_d[0] <= lane_a;
        r_w_d[0] <= lane_w;
        for (int k = 1; k < 4; k++) begin
            r_a_d[k] <= r_a_d[k-1];
            r_w_d[k] <= r_w_d[k-1];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mid[i] = r_w_d[1][i];
            a_al[i]  = r_a_d[3][i];
            w_al[i]  = r_w_d[3][i];
        end
    end

    // three lanes, one per body axis
    for (genvar i = 0; i < 3; i++) begin : g_lane
        assign arm_e[i] = get_entry(r_arm, i);

        ilac_rot_lane u_rot (
            .i_clk  (i_clk),
            .i_row  (r_rot[i]),
            .i_acc  (acc_in),
            .i_rate (rate_in),
            .o_a    (lane_a[i]),
            .o_w    (lane_w[i])
        );

        ilac_arm_lane u_arm (
            .i_clk (i_clk),
            .i_w1  (lane_w[(i+1)%3]),
            .i_w2  (lane_w[(i+2)%3]),
            .i_b1  (arm_e[(i+1)%3]),
            .i_b2  (arm_e[(i+2)%3]),
            .o_v   (lane_v[i])
        );

        ilac_cent_lane u_cent (
            .i_clk (i_clk),
            .i_w1  (w_mid[(i+1)%3]),
            .i_w2  (w_mid[(i+2)%3]),
            .i_v1  (lane_v[(i+1)%3]),
            .i_v2  (lane_v[(i+2)%3]),
            .o_c   (lane_c[i])
        );
    end

    // merge and output register
    ilac_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_vld[5]),
        .i_a       (a_al),
        .i_c       (lane_c),
        .i_w       (w_al),
        .o_acc     (out_acc),
        .o_rate    (out_rate),
        .o_clipped (o_clipped),
        .o_valid   (o_valid)
    );

    assign o_body_acc_x  = out_acc[0];
    assign o_body_acc_y  = out_acc[1];
    assign o_body_acc_z  = out_acc[2];
    assign o_body_rate_x = out_rate[0];
    assign o_body_rate_y = out_rate[1];
    assign o_body_rate_z = out_rate[2];

endmodule
